/* design/i2c_eeprom_byte_access_master_defines.svh */
// Assertion macros shared by the EEPROM master RTL.
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_DEFINES_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define EEM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eem check failed");

// Next-cycle implication, disabled while reset is low.
`define EEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eem check failed");

`endif

/* design/eem_pkg.sv */
// Types, codes and helpers for the I2C EEPROM byte-access master.
`default_nettype none
package eem_pkg;

    localparam int unsigned SDATA_W  = 24;
    localparam int unsigned SUSER_W  = 2;
    localparam int unsigned MDATA_W  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR   = 2'd0,
        CFG_POLL_LIMIT = 2'd1,
        CFG_SETTLE     = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    localparam logic [6:0]  DEV_ADDR_RST   = 7'd80;
    localparam logic [7:0]  POLL_LIMIT_RST = 8'd255;
    localparam logic [23:0] SETTLE_RST     = 24'd100;

    // Byte sent in a given slot: control byte, memory address, then data or read control.
    function automatic logic [7:0] byte_for_slot(
        input logic [6:0] dev_addr,
        input logic [2:0] slot,
        input logic       is_read,
        input logic [7:0] addr,
        input logic [7:0] data
    );
        logic [7:0] ctrl;
        ctrl = {dev_addr, 1'b0};
        if (slot == 3'd0) begin
            return ctrl;
        end else if (slot == 3'd1) begin
            return addr;
        end else if (is_read) begin
            return ctrl | 8'h01;
        end
        return data;
    endfunction

endpackage
`default_nettype wire

/* design/i2c_eeprom_byte_access_master.sv */
// I2C EEPROM byte-write / random-read master, one pin phase per tick transaction.
//
// Input stream: each accepted transaction is one tick. s_axis_tuser carries op
// (0 tick, 1 byte write, 2 random read, 3 acts as tick); a command is taken only
// while the sequencer is idle. s_axis_tdata carries mem_addr, write_data, sda_in.
// Output stream: exactly one result per tick with the scl/sda levels driven on that
// tick, busy, done, the last read byte and the missing-acknowledge flag.
// Config channel: write device_address (0), ack_poll_limit (1), settle_ticks (2)
// while idle; always ready, takes effect on the next tick.
// A tick's result is registered; one tick is accepted every cycle unless stalled.
// The result register is refilled in the cycle it is taken, so a stalled receiver
// stops input only while the held result waits (s_axis_tready follows m_axis_tready
// when the result register is full).
// Reset (synchronous, active low) returns the sequencer to idle with both lines
// released, clears the read byte and fault flag and loads the register defaults.
`default_nettype none
`include "i2c_eeprom_byte_access_master_defines.svh"
module i2c_eeprom_byte_access_master (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] mem_addr, [15:8] write_data, [16] sda_in, [23:17] zero
    input  wire logic [eem_pkg::SDATA_W-1:0]     s_axis_tdata,
    // [1:0] op
    input  wire logic [eem_pkg::SUSER_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_missing, [15:13] zero
    output logic [eem_pkg::MDATA_W-1:0]          m_axis_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [eem_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [eem_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import eem_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_W0, PH_B0, PH_B1, PH_B2, PH_B3,
        PH_ACK, PH_ACKEND, PH_RHIGH, PH_RLOW, PH_RREL, PH_P0, PH_P1, PH_P2, PH_SETTLE
    } t_phase;

    logic [6:0]  r_dev_addr;
    logic [7:0]  r_poll_limit;
    logic [23:0] r_settle_ticks;

    t_phase      r_phase, n_phase, cur_phase;
    logic [2:0]  r_bit_index, n_bit_index;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_poll_count, n_poll_count;
    logic [23:0] r_settle_count, n_settle_count;
    logic        r_is_read, n_is_read;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic [2:0]  r_byte_index, n_byte_index;
    logic        r_ack_fault, n_ack_fault;
    logic [7:0]  r_read_hold, n_read_hold;

    logic                 r_out_valid;
    logic [MDATA_W-1:0]   r_out;

    logic       in_acc;
    t_op        op;
    logic [7:0] in_mem_addr, in_write_data;
    logic       in_sda;
    logic       scl, sda, busy, done, msb;
    logic [2:0] next_byte_index;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign o_cfg_ready   = 1'b1;

    assign op            = t_op'(s_axis_tuser[1:0]);
    assign in_mem_addr   = s_axis_tdata[7:0];
    assign in_write_data = s_axis_tdata[15:8];
    assign in_sda        = s_axis_tdata[16];
    assign msb           = r_shift[7];
    assign next_byte_index = r_byte_index + 3'd1;

    always_comb begin
        n_phase        = r_phase;
        n_bit_index    = r_bit_index;
        n_shift        = r_shift;
        n_poll_count   = r_poll_count;
        n_settle_count = r_settle_count;
        n_is_read      = r_is_read;
        n_addr         = r_addr;
        n_data         = r_data;
        n_byte_index   = r_byte_index;
        n_ack_fault    = r_ack_fault;
        n_read_hold    = r_read_hold;
        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b1;
        done = 1'b0;
        cur_phase = r_phase;

        // A command starts only from idle and runs its first phase on the same tick.
        if (r_phase == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
            n_is_read    = (op == OP_READ);
            n_addr       = in_mem_addr;
            if (op == OP_WRITE) begin
                n_data = in_write_data;
            end
            n_ack_fault  = 1'b0;
            n_byte_index = 3'd0;
            cur_phase    = PH_S0;
        end

        case (cur_phase)
            PH_S0: begin
                scl = 1'b0; n_phase = PH_S1;
            end
            PH_S1: begin
                n_phase = PH_S2;
            end
            PH_S2: begin
                sda = 1'b0;
                n_shift = byte_for_slot(r_dev_addr, n_byte_index, n_is_read, n_addr, n_data);
                n_bit_index = 3'd0;
                n_phase = PH_W0;
            end
            PH_W0: begin
                scl = 1'b0; sda = 1'b0; n_phase = PH_B0;
            end
            PH_B0: begin
                scl = 1'b0; sda = msb; n_phase = PH_B1;
            end
            PH_B1: begin
                sda = msb; n_phase = PH_B2;
            end
            PH_B2: begin
                scl = 1'b0; sda = msb; n_phase = PH_B3;
            end
            PH_B3: begin
                scl = 1'b0;
                n_shift = {r_shift[6:0], 1'b0};
                n_bit_index = r_bit_index + 3'd1;
                if (r_bit_index == 3'd7) begin
                    n_poll_count = r_poll_limit;
                    n_phase = PH_ACK;
                end else begin
                    n_phase = PH_B0;
                end
            end
            PH_ACK: begin
                if (!in_sda) begin
                    n_phase = PH_ACKEND;
                end else if (r_poll_count == 8'd0) begin
                    n_ack_fault = 1'b1;
                    n_phase = PH_ACKEND;
                end else begin
                    n_poll_count = r_poll_count - 8'd1;
                end
            end
            PH_ACKEND: begin
                scl = 1'b0;
                n_byte_index = next_byte_index;
                if (next_byte_index == 3'd1 || (next_byte_index == 3'd2 && !r_is_read)) begin
                    n_shift = byte_for_slot(r_dev_addr, next_byte_index, r_is_read,
                                            r_addr, r_data);
                    n_bit_index = 3'd0;
                    n_phase = PH_B0;
                end else if (next_byte_index == 3'd2) begin
                    // repeated start before the read control byte
                    n_phase = PH_S0;
                end else if (next_byte_index == 3'd3 && r_is_read) begin
                    n_bit_index = 3'd0;
                    n_phase = PH_RHIGH;
                end else begin
                    n_phase = PH_P0;
                end
            end
            PH_RHIGH: begin
                n_shift = {r_shift[6:0], in_sda};
                n_phase = PH_RLOW;
            end
            PH_RLOW: begin
                scl = 1'b0; n_phase = PH_RREL;
            end
            PH_RREL: begin
                scl = 1'b0;
                n_bit_index = r_bit_index + 3'd1;
                if (r_bit_index == 3'd7) begin
                    n_read_hold = r_shift;
                    n_phase = PH_P0;
                end else begin
                    n_phase = PH_RHIGH;
                end
            end
            PH_P0: begin
                scl = 1'b0; sda = 1'b0; n_phase = PH_P1;
            end
            PH_P1: begin
                sda = 1'b0; n_phase = PH_P2;
            end
            PH_P2: begin
                n_settle_count = r_settle_ticks;
                n_phase = PH_SETTLE;
            end
            PH_SETTLE: begin
                if (r_settle_count == 24'd0) begin
                    done = 1'b1; busy = 1'b0;
                    n_phase = PH_IDLE;
                end else begin
                    n_settle_count = r_settle_count - 24'd1;
                end
            end
            default: begin
                busy = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr     <= DEV_ADDR_RST;
            r_poll_limit   <= POLL_LIMIT_RST;
            r_settle_ticks <= SETTLE_RST;
            r_phase        <= PH_IDLE;
            r_bit_index    <= 3'd0;
            r_shift        <= 8'd0;
            r_poll_count   <= 8'd0;
            r_settle_count <= 24'd0;
            r_is_read      <= 1'b0;
            r_addr         <= 8'd0;
            r_data         <= 8'd0;
            r_byte_index   <= 3'd0;
            r_ack_fault    <= 1'b0;
            r_read_hold    <= 8'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DEV_ADDR:   r_dev_addr     <= i_cfg_data[6:0];
                    CFG_POLL_LIMIT: r_poll_limit   <= i_cfg_data[7:0];
                    CFG_SETTLE:     r_settle_ticks <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_phase        <= n_phase;
                r_bit_index    <= n_bit_index;
                r_shift        <= n_shift;
                r_poll_count   <= n_poll_count;
                r_settle_count <= n_settle_count;
                r_is_read      <= n_is_read;
                r_addr         <= n_addr;
                r_data         <= n_data;
                r_byte_index   <= n_byte_index;
                r_ack_fault    <= n_ack_fault;
                r_read_hold    <= n_read_hold;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload: load with each accepted tick.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= {3'b000, n_ack_fault, n_read_hold, done, busy, sda, scl};
        end
    end

    `EEM_ASSERT_NEXT(a_tick_gives_result, i_clk, i_rst_n, in_acc, r_out_valid)
    `EEM_ASSERT_NEXT(a_settle_ends_idle, i_clk, i_rst_n,
        in_acc && r_phase == PH_SETTLE && r_settle_count == 24'd0,
        r_phase == PH_IDLE && r_out[3] && !r_out[2])
    `EEM_ASSERT_NEXT(a_ack_timeout_flags, i_clk, i_rst_n,
        in_acc && r_phase == PH_ACK && in_sda && r_poll_count == 8'd0,
        r_ack_fault && r_phase == PH_ACKEND)
    `EEM_ASSERT_NOW(a_read_phase_only_on_read, i_clk, i_rst_n,
        r_phase == PH_RHIGH || r_phase == PH_RLOW || r_phase == PH_RREL, r_is_read)
    `EEM_ASSERT_NOW(a_ack_on_byte_boundary, i_clk, i_rst_n,
        r_phase == PH_ACK, r_bit_index == 3'd0)

endmodule
`default_nettype wire
